FILE: hdl/stx_etx_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// STX/ETX frame parser assertion macros
// Property wrappers shared by the parser's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_PARSER_ASSERT_SVH
`define STX_ETX_FRAME_PARSER_ASSERT_SVH

// Check a same-cycle implication, masked while reset is low
`define SEFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame parser check failed");

// Check an implication in the following cycle, masked while reset is low
`define SEFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame parser check failed");

`endif

FILE: hdl/sefp_pkg.sv
// ----------------------------------------------------------------------------
// STX/ETX frame parser package
// Parse step and link status codes plus the frame marker bytes.
// ----------------------------------------------------------------------------
package sefp_pkg;

    localparam logic [7:0] MARK_ESC = 8'hFF;
    localparam logic [7:0] MARK_STX = 8'h02;
    localparam logic [7:0] MARK_ETX = 8'h03;

    typedef enum logic [3:0] {
        P_STX1    = 4'd0,
        P_STX2    = 4'd1,
        P_ADDR_HI = 4'd2,
        P_ADDR_LO = 4'd3,
        P_LEN_HI  = 4'd4,
        P_LEN_LO  = 4'd5,
        P_CMD_HI  = 4'd6,
        P_CMD_LO  = 4'd7,
        P_DATA    = 4'd8,
        P_ETX1    = 4'd9,
        P_ETX2    = 4'd10
    } parse_step_t;

    typedef enum logic [1:0] {
        ST_WAIT = 2'd0,
        ST_RECV = 2'd1,
        ST_DONE = 2'd2
    } link_status_t;

endpackage

FILE: hdl/stx_etx_frame_parser.sv
// ----------------------------------------------------------------------------
// STX/ETX frame parser
// Parses FF 02 / addr / len / cmd / payload / FF 03 byte frames, one result
// beat per received byte, payload streamed out with its index.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_stall  | rx_data_byte
//  output   | out_valid / out_stall| frame_status, frame_done, frame_error,
//           |                      | frame_addr, frame_len, frame_cmd,
//           |                      | payload_valid, payload_byte, payload_index
//
//  One byte per cycle while not stalled: the parse state updates in the accept
//  cycle and the result beat appears in the next cycle from the output register.
//  The output register is the only buffer; input stalls only while it holds
//  a beat that the downstream side stalls.
//  Reset clears the parse step, status, header fields and payload count.
// ----------------------------------------------------------------------------
module stx_etx_frame_parser
    import sefp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  frame_status,
    output logic        frame_done,
    output logic        frame_error,
    output logic [15:0] frame_addr,
    output logic [15:0] frame_len,
    output logic [15:0] frame_cmd,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [15:0] payload_index
);

    parse_step_t  step_reg,   step_next;
    link_status_t status_reg, status_next;
    logic [15:0]  addr_reg,   addr_next;
    logic [15:0]  len_reg,    len_next;
    logic [15:0]  cmd_reg,    cmd_next;
    logic [15:0]  count_reg,  count_next;
    logic [15:0]  count_inc;
    logic         done_c;
    logic         error_c;
    logic         pv_c;
    logic [7:0]   pbyte_c;
    logic [15:0]  pidx_c;
    logic         accept;

    // Result register
    logic         out_valid_reg, out_valid_next;
    logic         done_reg;
    logic         error_reg;
    logic         pv_reg;
    logic [7:0]   pbyte_reg;
    logic [15:0]  pidx_reg;

    // Take a beat when the result register is free or draining
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign count_inc = count_reg + 16'd1;

    // Next parse step, link status and marker pulses
    always_comb
    begin
        step_next   = step_reg;
        status_next = status_reg;
        done_c      = 1'b0;
        error_c     = 1'b0;
        case (step_reg)
            P_STX2:
            begin
                if (rx_data_byte == MARK_STX)
                begin
                    step_next = P_ADDR_HI;
                end
                else
                begin
                    step_next   = P_STX1;
                    status_next = ST_WAIT;
                    error_c     = 1'b1;
                end
            end
            P_ADDR_HI: step_next = P_ADDR_LO;
            P_ADDR_LO: step_next = P_LEN_HI;
            P_LEN_HI:  step_next = P_LEN_LO;
            P_LEN_LO:  step_next = P_CMD_HI;
            P_CMD_HI:  step_next = P_CMD_LO;
            P_CMD_LO:  step_next = (len_reg != 16'd0) ? P_DATA : P_ETX1;
            P_DATA:
            begin
                if (count_inc == len_reg)
                begin
                    step_next = P_ETX1;
                end
            end
            P_ETX1:
            begin
                if (rx_data_byte == MARK_ESC)
                begin
                    step_next = P_ETX2;
                end
                else
                begin
                    step_next   = P_STX1;
                    status_next = ST_WAIT;
                    error_c     = 1'b1;
                end
            end
            P_ETX2:
            begin
                step_next = P_STX1;
                if (rx_data_byte == MARK_ETX)
                begin
                    status_next = ST_DONE;
                    done_c      = 1'b1;
                end
                else
                begin
                    status_next = ST_WAIT;
                    error_c     = 1'b1;
                end
            end
            default:
            begin
                // Waiting for the first start byte; noise is dropped
                if (rx_data_byte == MARK_ESC)
                begin
                    step_next   = P_STX2;
                    status_next = ST_RECV;
                end
                else
                begin
                    step_next = P_STX1;
                end
            end
        endcase
    end

    // Header fields, payload count and payload beat
    always_comb
    begin
        addr_next  = addr_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        count_next = count_reg;
        pv_c       = 1'b0;
        pbyte_c    = 8'd0;
        pidx_c     = 16'd0;
        case (step_reg)
            P_ADDR_HI: addr_next = {rx_data_byte, 8'd0};
            P_ADDR_LO: addr_next = {addr_reg[15:8], rx_data_byte};
            P_LEN_HI:  len_next  = {rx_data_byte, 8'd0};
            P_LEN_LO:  len_next  = {len_reg[15:8], rx_data_byte};
            P_CMD_HI:  cmd_next  = {rx_data_byte, 8'd0};
            P_CMD_LO:  cmd_next  = {cmd_reg[15:8], rx_data_byte};
            P_DATA:
            begin
                pv_c       = 1'b1;
                pbyte_c    = rx_data_byte;
                pidx_c     = count_reg;
                count_next = count_inc;
            end
            P_STX2, P_ETX1, P_ETX2:
            begin
                count_next = count_reg;
            end
            default:
            begin
                // Restart the payload count on a fresh start byte
                if (rx_data_byte == MARK_ESC)
                begin
                    count_next = 16'd0;
                end
            end
        endcase
    end

    // Hold the result beat while stalled, clear it once taken
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Advance parser state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= P_STX1;
            status_reg    <= ST_WAIT;
            addr_reg      <= 16'd0;
            len_reg       <= 16'd0;
            cmd_reg       <= 16'd0;
            count_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                step_reg   <= step_next;
                status_reg <= status_next;
                addr_reg   <= addr_next;
                len_reg    <= len_next;
                cmd_reg    <= cmd_next;
                count_reg  <= count_next;
            end
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            done_reg  <= done_c;
            error_reg <= error_c;
            pv_reg    <= pv_c;
            pbyte_reg <= pbyte_c;
            pidx_reg  <= pidx_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_status  = status_reg;
    assign frame_done    = done_reg;
    assign frame_error   = error_reg;
    assign frame_addr    = addr_reg;
    assign frame_len     = len_reg;
    assign frame_cmd     = cmd_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pidx_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
`include "stx_etx_frame_parser_assert.svh"

    `SEFP_ASSERT_NOW(a_done_status, clk, rst_n, out_valid_reg && done_reg, status_reg == ST_DONE)
    `SEFP_ASSERT_NOW(a_payload_recv, clk, rst_n, out_valid_reg && pv_reg, status_reg == ST_RECV)
    `SEFP_ASSERT_NEXT(a_data_beat, clk, rst_n, accept && step_reg == P_DATA, out_valid_reg && pv_reg)
    `SEFP_ASSERT_NEXT(a_bad_stx, clk, rst_n, accept && step_reg == P_STX2 && rx_data_byte != MARK_STX, error_reg && step_reg == P_STX1)

endmodule
